FILE: sv/slwr_pkg.sv
// Shared types and constants for the shortlex word/rank codec.
// No dependencies; imported by slwr_cell, slwr_mac and the top level.
package slwr_pkg;

  localparam int DIGIT_BITS = 4;
  localparam int MAX_LEN    = 16;
  localparam int DATA_W     = 64;
  localparam int LEN_W      = 5;
  localparam int RADIX_W    = DIGIT_BITS + 1;
  localparam int ADD_W      = DIGIT_BITS + 1;
  localparam int STAT_W     = 2;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(1 << DIGIT_BITS);

  localparam int IN_BITS    = LEN_W + 2 * DATA_W;
  localparam int OUT_BITS   = DATA_W + LEN_W + DATA_W;
  localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVF       = 2'd1,
    STAT_BAD_DIGIT = 2'd2
  } slwr_status_t;

  // One hop of the divider chain: a quotient bit and its qualifier.
  typedef struct packed {
    logic vld;
    logic qbit;
  } slwr_link_t;

endpackage

FILE: sv/slwr_cell.sv
// One cell of the base-radix divider chain: serial remainder step on a bit stream.
// Depends on slwr_pkg.
module slwr_cell import slwr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clr,
  input  logic [RADIX_W-1:0]    r,
  input  slwr_link_t            lin,
  output slwr_link_t            lout,
  output logic [DIGIT_BITS-1:0] rem
);

  logic [DIGIT_BITS:0]   wide;
  logic                  take;
  logic [DIGIT_BITS:0]   diff;
  logic [DIGIT_BITS-1:0] rem_next;

  always_comb begin
    wide     = {rem, lin.qbit};
    take     = (wide >= r);
    diff     = wide - r;
    rem_next = take ? diff[DIGIT_BITS-1:0] : wide[DIGIT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      rem       <= '0;
      lout.vld  <= 1'b0;
      lout.qbit <= 1'b0;
    end else begin
      lout.vld  <= lin.vld;
      lout.qbit <= take;
      if (lin.vld) begin
        rem <= rem_next;
      end
    end
  end

  // remainder always stays a valid digit
  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, rem} < r))
    else $error("cell remainder not below radix");

  // a quotient bit leaves only for a bit that came in
  a_vld_follows: assert property (@(posedge clk) disable iff (rst)
    lout.vld |-> $past(lin.vld))
    else $error("cell produced an unqualified quotient bit");

  // clearing restarts the cell
  a_clr_zero: assert property (@(posedge clk) disable iff (rst)
    $past(clr) |-> (rem == '0) && !lout.vld)
    else $error("cell not cleared");

endmodule

FILE: sv/slwr_mac.sv
// Multiply-accumulate step acc*mul + add with overflow detect beyond DATA_W bits.
// Depends on slwr_pkg.
module slwr_mac import slwr_pkg::*; (
  input  logic [DATA_W-1:0]  acc,
  input  logic [RADIX_W-1:0] mul,
  input  logic [ADD_W-1:0]   add,
  output logic [DATA_W-1:0]  sum,
  output logic               ovf
);

  localparam int PROD_W = DATA_W + RADIX_W;

  logic [PROD_W-1:0] prod;
  logic [PROD_W:0]   total;

  // shift-and-add over the few multiplier bits
  always_comb begin
    prod = '0;
    for (int b = 0; b < RADIX_W; b++) begin
      if (mul[b]) begin
        prod = prod + (PROD_W'(acc) << b);
      end
    end
    total = (PROD_W+1)'(prod) + (PROD_W+1)'(add);
    sum   = total[DATA_W-1:0];
    ovf   = |total[PROD_W:DATA_W];
  end

endmodule

FILE: sv/shortlex_word_rank_codec_core.sv
// Shortlex word/rank codec core; depends on slwr_pkg, slwr_mac and slwr_cell.
// Flow (transfer to result): encode runs one Horner step per letter, then ST_DONE;
//   rejects go straight to ST_DONE, overflow ends early. Decode runs the length search,
//   then the divider chain, then ST_DONE; a too-long word ends from the length search.
// Throughput: one item at a time, the next transfer taken once the result is registered.
// Reset (rst, synchronous, active high): idle, output empty, radix back to 2.
module shortlex_word_rank_codec_core import slwr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // radix register write
  input  logic                 cfg_wr_en,
  input  logic [RADIX_W-1:0]   cfg_wr_data,
  // request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [4:0] word_length, [68:5] word_digits, [132:69] rank_in, rest zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] req_type
  input  logic [0:0]           s_axis_tuser,
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [63:0] rank_out, [68:64] length_out, [132:69] digits_out, rest zero
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [STAT_W-1:0]    m_axis_tuser
);

  localparam int DIV_LAST = DATA_W + MAX_LEN - 2;
  localparam int CNT_W    = $clog2(DIV_LAST + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC,
    ST_OFS,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;

  // configuration
  logic [RADIX_W-1:0] radix;
  logic [RADIX_W-1:0] r_eff;
  logic [RADIX_W-1:0] r_q;

  // working registers
  logic [CNT_W-1:0]   cnt;
  logic [LEN_W-1:0]   len_q;
  logic [DATA_W-1:0]  val;       // digits (encode) or rank / residue (decode)
  logic [DATA_W-1:0]  acc;       // rank (encode) or offset of next length (decode)
  logic [DATA_W-1:0]  s_cur;     // offset of the current length
  logic               nxt_ovf;
  logic [LEN_W-1:0]   dec_len;
  logic [DATA_W-1:0]  res_rank;
  slwr_status_t       res_stat;
  logic               res_dec;

  // input fields
  logic                 in_req;
  logic [LEN_W-1:0]     in_len;
  logic [DATA_W-1:0]    in_digits;
  logic [DATA_W-1:0]    in_rank;
  logic                 in_bad;
  logic                 accept;

  // MAC
  logic [ADD_W-1:0]      mac_add;
  logic [DATA_W-1:0]     mac_sum;
  logic                  mac_ovf;
  logic [DIGIT_BITS-1:0] nib;

  // divider chain
  slwr_link_t                            links [MAX_LEN+1];
  logic [MAX_LEN-1:0][DIGIT_BITS-1:0]    rem_all;
  logic [MAX_LEN-1:0][DIGIT_BITS-1:0]    rem_rev;
  logic [LEN_W-1:0]                      pad_cnt;
  logic [CNT_W-1:0]                      shamt;
  logic                                  dec_ok;
  logic [DATA_W-1:0]                     out_digits;
  logic [LEN_W-1:0]                      out_len;

  // out-of-range radix clamps to 1 .. 2^DIGIT_BITS
  always_comb begin
    if (radix == '0) begin
      r_eff = RADIX_W'(1);
    end else if (radix > RADIX_MAX) begin
      r_eff = RADIX_MAX;
    end else begin
      r_eff = radix;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_req    = s_axis_tuser[0];
  assign in_len    = s_axis_tdata[LEN_W-1:0];
  assign in_digits = s_axis_tdata[LEN_W+DATA_W-1:LEN_W];
  assign in_rank   = s_axis_tdata[LEN_W+2*DATA_W-1:LEN_W+DATA_W];

  // any used letter not below radix
  always_comb begin
    in_bad = 1'b0;
    for (int i = 0; i < MAX_LEN; i++) begin
      if ((LEN_W'(i) < in_len) &&
          ({1'b0, in_digits[i*DIGIT_BITS +: DIGIT_BITS]} >= r_eff)) begin
        in_bad = 1'b1;
      end
    end
  end

  // Horner step for encode; offset recurrence S' = S*r + r for the length search
  assign nib = val[DIGIT_BITS-1:0];
  always_comb begin
    if (state == ST_OFS) begin
      mac_add = r_q;
    end else if (cnt == '0) begin
      mac_add = ADD_W'(nib);
    end else begin
      mac_add = r_q + ADD_W'(nib);
    end
  end

  slwr_mac u_mac (
    .acc (acc),
    .mul (r_q),
    .add (mac_add),
    .sum (mac_sum),
    .ovf (mac_ovf)
  );

  // Divider chain: the residue streams in MSB first; cell j ends holding
  // digit j of the residue in base r (cell 0 least significant).
  assign links[0].vld  = (state == ST_DIV) && (cnt < CNT_W'(DATA_W));
  assign links[0].qbit = val[DATA_W-1];

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    slwr_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .clr  (accept),
      .r    (r_q),
      .lin  (links[j]),
      .lout (links[j+1]),
      .rem  (rem_all[j])
    );
    assign rem_rev[j] = rem_all[MAX_LEN-1-j];
  end

  // First letter is the most significant digit: reverse, then drop the padding.
  always_comb begin
    pad_cnt    = LEN_W'(MAX_LEN) - dec_len;
    shamt      = CNT_W'(DIGIT_BITS) * CNT_W'(pad_cnt);
    dec_ok     = res_dec && (res_stat == STAT_OK);
    out_len    = dec_ok ? dec_len : '0;
    out_digits = dec_ok ? (DATA_W'(rem_rev) >> shamt) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      radix         <= RADIX_RESET;
      r_q           <= RADIX_W'(1);
      m_axis_tvalid <= 1'b0;
      cnt           <= '0;
    end else begin
      if (cfg_wr_en) begin
        radix <= cfg_wr_data;
      end

      // drop the result once taken, unless a new one replaces it
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            r_q      <= r_eff;
            cnt      <= '0;
            res_dec  <= in_req;
            if (in_req == REQ_DECODE) begin
              res_rank <= '0;
              res_stat <= STAT_OK;
              val      <= in_rank;
              s_cur    <= '0;
              acc      <= DATA_W'(r_eff);
              nxt_ovf  <= 1'b0;
              dec_len  <= LEN_W'(1);
              state    <= ST_OFS;
            end else begin
              val   <= in_digits;
              acc   <= '0;
              len_q <= in_len;
              if (in_len == '0) begin
                res_rank <= '0;
                res_stat <= STAT_OVF;
                state    <= ST_DONE;
              end else if (in_len > LEN_W'(MAX_LEN)) begin
                res_stat <= STAT_OVF;
                res_rank <= '1;
                state    <= ST_DONE;
              end else if (in_bad) begin
                res_rank <= '0;
                res_stat <= STAT_BAD_DIGIT;
                state    <= ST_DONE;
              end else begin
                res_rank <= '0;
                res_stat <= STAT_OK;
                state    <= ST_ENC;
              end
            end
          end
        end

        ST_ENC: begin
          if (mac_ovf) begin
            res_rank <= '1;
            res_stat <= STAT_OVF;
            state    <= ST_DONE;
          end else begin
            acc <= mac_sum;
            val <= val >> DIGIT_BITS;
            cnt <= cnt + CNT_W'(1);
            if (cnt == CNT_W'(len_q) - CNT_W'(1)) begin
              res_rank <= mac_sum;
              state    <= ST_DONE;
            end
          end
        end

        ST_OFS: begin
          // length found once the rank lies below the next offset
          if (nxt_ovf || (val < acc)) begin
            val   <= val - s_cur;
            cnt   <= '0;
            state <= ST_DIV;
          end else if (dec_len == LEN_W'(MAX_LEN)) begin
            res_stat <= STAT_OVF;
            state    <= ST_DONE;
          end else begin
            s_cur   <= acc;
            acc     <= mac_sum;
            nxt_ovf <= mac_ovf;
            dec_len <= dec_len + LEN_W'(1);
          end
        end

        ST_DIV: begin
          if (cnt < CNT_W'(DATA_W)) begin
            val <= val << 1;
          end
          cnt <= cnt + CNT_W'(1);
          // hold until the last cell has seen the last bit
          if (cnt == CNT_W'(DIV_LAST)) begin
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= M_TDATA_W'({out_digits, out_len, res_rank});
            m_axis_tuser  <= res_stat;
            state         <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // an accepted request always starts work
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted request did not start");

  // the output register is loaded only from the completion state
  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_DONE))
    else $error("result appeared outside completion");

  // the encode step counter never runs past the word
  a_enc_in_word: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ENC) |-> (cnt < CNT_W'(len_q)))
    else $error("encode ran past the word length");

endmodule

FILE: bench/tb_shortlex_word_rank_codec_core.sv
// Self-checking bench for shortlex_word_rank_codec_core: directed and random
// encode/decode requests with a scoreboard that predicts every result.
// Depends on slwr_pkg and the core RTL only.
module tb_shortlex_word_rank_codec_core import slwr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 3000;  // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES = 120;   // longer than the slowest decode
  localparam int SEGMENTS     = 15;
  localparam int SEG_ITEMS    = 50;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    logic [DATA_W-1:0] rank;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] digits;
    slwr_status_t      status;
  } codec_result_t;

  // Predicts each conversion and matches it against what comes out of the core.
  class shortlex_scoreboard;
    logic [RADIX_W-1:0] radix_q;
    codec_result_t      expected_q[$];
    int unsigned        mismatches;

    function new();
      radix_q    = RADIX_RESET;
      mismatches = 0;
    endfunction

    function void set_radix(logic [RADIX_W-1:0] value);
      radix_q = value;
    endfunction

    // Radix 0 behaves as 1, anything above 1<<DIGIT_BITS clamps there.
    function int unsigned effective_radix();
      if (radix_q == 0) return 1;
      if (radix_q > RADIX_MAX) return RADIX_MAX;
      return radix_q;
    endfunction

    function codec_result_t predict_conversion(logic req, logic [LEN_W-1:0] len,
                                               logic [DATA_W-1:0] digits,
                                               logic [DATA_W-1:0] rank_in);
      codec_result_t     res;
      logic [DATA_W-1:0] r, acc, add, n, word_bits, d;
      logic [DIGIT_BITS-1:0] letters [64];
      int                m;
      logic              bad, ovf;
      res.rank   = '0;
      res.len    = '0;
      res.digits = '0;
      res.status = STAT_OK;
      r = effective_radix();
      if (req == REQ_ENCODE) begin
        if (len == 0) begin
          res.status = STAT_OVF;
        end else if (len > MAX_LEN) begin
          res.rank   = '1;
          res.status = STAT_OVF;
        end else begin
          bad = 1'b0;
          for (int i = 0; i < len; i++)
            if (digits[i*DIGIT_BITS +: DIGIT_BITS] >= r) bad = 1'b1;
          if (bad) begin
            res.status = STAT_BAD_DIGIT;
          end else begin
            // rank = rank*radix + radix + letter, refusing to wrap past 64 bits
            ovf = 1'b0;
            acc = '0;
            for (int i = 0; i < len; i++) begin
              d = digits[i*DIGIT_BITS +: DIGIT_BITS];
              if (i == 0) begin
                acc = d;
              end else if (!ovf) begin
                add = r + d;
                if (acc > ({DATA_W{1'b1}} - add) / r) ovf = 1'b1;
                else acc = acc * r + add;
              end
            end
            if (ovf) begin
              res.rank   = '1;
              res.status = STAT_OVF;
            end else begin
              res.rank = acc;
            end
          end
        end
      end else if (r == 1) begin
        if (rank_in >= MAX_LEN) res.status = STAT_OVF;
        else res.len = LEN_W'(rank_in + 1);
      end else begin
        // bijective base-radix digits, last letter first
        letters[0] = DIGIT_BITS'(rank_in % r);
        m = 1;
        n = rank_in / r;
        while (n > 0 && m < 64) begin
          n = n - 1;
          letters[m] = DIGIT_BITS'(n % r);
          m++;
          n = n / r;
        end
        if (m > MAX_LEN) begin
          res.status = STAT_OVF;
        end else begin
          word_bits = '0;
          for (int i = 0; i < m; i++)
            word_bits[i*DIGIT_BITS +: DIGIT_BITS] = letters[m-1-i];
          res.len    = LEN_W'(m);
          res.digits = word_bits;
        end
      end
      return res;
    endfunction

    function void note_request(logic req, logic [LEN_W-1:0] len,
                               logic [DATA_W-1:0] digits, logic [DATA_W-1:0] rank_in);
      expected_q.insert(expected_q.size(), predict_conversion(req, len, digits, rank_in));
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] tdata, logic [STAT_W-1:0] tuser);
      codec_result_t got, want;
      got.rank   = tdata[DATA_W-1:0];
      got.len    = tdata[DATA_W +: LEN_W];
      got.digits = tdata[DATA_W+LEN_W +: DATA_W];
      got.status = slwr_status_t'(tuser);
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result rank=%h len=%0d digits=%h status=%0d",
                   $realtime, got.rank, got.len, got.digits, got.status);
      end else begin
        want = expected_q.pop_front();
        if (got.rank !== want.rank || got.len !== want.len ||
            got.digits !== want.digits || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp rank=%h len=%0d digits=%h status=%0d", $realtime,
                     want.rank, want.len, want.digits, want.status,
                     " | got rank=%h len=%0d digits=%h status=%0d",
                     got.rank, got.len, got.digits, got.status);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [RADIX_W-1:0]   cfg_wr_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [0:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]    m_axis_tuser;

  shortlex_scoreboard scoreboard;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_len     = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  shortlex_word_rank_codec_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      scoreboard.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Watchdog: stop when neither side has moved a transfer for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[shortlex_word_rank_codec_core] ERROR");
      $finish;
    end
  end

  // Offer one request, idling first at random; returns at a clock edge once s_axis_tready is seen high.
  task automatic push_request(logic req, logic [LEN_W-1:0] len,
                              logic [DATA_W-1:0] digits, logic [DATA_W-1:0] rank_in);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({rank_in, digits, len});
    s_axis_tuser  <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    scoreboard.note_request(req, len, digits, rank_in);
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
  endtask

  // Write the radix register while the core is idle.
  task automatic write_radix(logic [RADIX_W-1:0] value);
    settle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scoreboard.set_radix(value);
  endtask

  // Mostly legal words and decodable ranks, with some raw noise mixed in.
  task automatic random_request();
    int unsigned       pick, r, len;
    logic [DATA_W-1:0] digits, rank_in;
    pick    = $urandom_range(99);
    r       = scoreboard.effective_radix();
    digits  = {$urandom, $urandom};
    rank_in = {$urandom, $urandom};
    if (pick < 45) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(9, MAX_LEN) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
        digits[i*DIGIT_BITS +: DIGIT_BITS] = DIGIT_BITS'($urandom_range(r - 1));
      push_request(REQ_ENCODE, LEN_W'(len), digits, rank_in);
    end else if (pick < 80) begin
      // shift down so that short words turn up as often as long ones
      push_request(REQ_DECODE, LEN_W'($urandom), digits, rank_in >> $urandom_range(63));
    end else begin
      push_request(1'($urandom_range(1)), LEN_W'($urandom_range(31)), digits, rank_in);
    end
  endtask

  logic [RADIX_W-1:0] radix_plan [SEGMENTS] = '{
    5'd3, 5'd16, 5'd1, 5'd10, 5'd0, 5'd31, 5'd7, 5'd2,
    5'd17, 5'd5, 5'd16, 5'd4, 5'd9, 5'd1, 5'd12
  };

  initial begin
    scoreboard = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset radix of 2: lengths, bad letters, decode limits.
    push_request(REQ_ENCODE, 5'd1, 64'h0, 64'h0);
    push_request(REQ_ENCODE, 5'd1, 64'h1, 64'h0);
    push_request(REQ_ENCODE, 5'd0, 64'h0, 64'h0);                  // empty word
    push_request(REQ_ENCODE, 5'd17, 64'h0, 64'h0);                 // one letter too many
    push_request(REQ_ENCODE, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF, '1);  // length field maxed
    push_request(REQ_ENCODE, 5'd3, 64'h020, 64'h0);                // letter equal to radix
    push_request(REQ_ENCODE, 5'd2, 64'hFFFF_FFFF_FFFF_FF10, 64'h0); // junk past the word
    push_request(REQ_ENCODE, 5'd16, 64'h1111_1111_1111_1111, 64'h0);
    push_request(REQ_DECODE, 5'd0, 64'h0, 64'h0);
    push_request(REQ_DECODE, 5'd0, 64'h0, '1);                     // far too long
    push_request(REQ_DECODE, 5'd31, '1, 64'd5);                    // word fields ignored
    push_request(REQ_DECODE, 5'd0, 64'h0, 64'd131069);             // last rank of length 16
    push_request(REQ_DECODE, 5'd0, 64'h0, 64'd131070);             // first rank of length 17

    write_radix(5'd16);
    push_request(REQ_ENCODE, 5'd16, '1, 64'h0);                    // rank past 64 bits
    push_request(REQ_ENCODE, 5'd16, 64'h0, 64'h0);
    push_request(REQ_ENCODE, 5'd1, 64'hF, 64'h0);
    push_request(REQ_DECODE, 5'd0, 64'h0, '1);

    write_radix(5'd1);
    push_request(REQ_ENCODE, 5'd5, 64'h0, 64'h0);
    push_request(REQ_ENCODE, 5'd3, 64'h010, 64'h0);
    push_request(REQ_DECODE, 5'd0, 64'h0, 64'd15);
    push_request(REQ_DECODE, 5'd0, 64'h0, 64'd16);

    write_radix(5'd0);                                             // behaves as 1
    push_request(REQ_ENCODE, 5'd16, 64'h0, 64'h0);
    push_request(REQ_DECODE, 5'd0, 64'h0, 64'd3);

    write_radix(5'd31);                                            // clamps to 16
    push_request(REQ_ENCODE, 5'd2, 64'hFF, 64'h0);
    push_request(REQ_DECODE, 5'd0, 64'h0, '1);

    // Random part: sender-light then receiver-light idling, then full rate.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 5) begin
        snd_idle_pct = 17;
        rcv_idle_pct = 83;
      end else if (seg < 10) begin
        snd_idle_pct = 83;
        rcv_idle_pct = 17;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      write_radix(radix_plan[seg]);
      for (int k = 0; k < SEG_ITEMS; k++) begin
        // stall the output while requests keep coming, so the input backs up
        if (seg == 1 && k == 10) hold_len = HOLD_CYCLES;
        random_request();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
      $display("[shortlex_word_rank_codec_core] OK");
    end else begin
      $display("[shortlex_word_rank_codec_core] ERROR");
    end
    $finish;
  end

endmodule
